// ===== src/control_interval_insert_split_unit_defines.svh =====
// Assertion macros shared by the control interval insert/split unit.
// Depends on nothing; included by modules that assert.
`ifndef CONTROL_INTERVAL_INSERT_SPLIT_UNIT_DEFINES_SVH
`define CONTROL_INTERVAL_INSERT_SPLIT_UNIT_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define CIIS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define CIIS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== src/ciis_pkg.sv =====
// Package for the control interval insert/split unit: types, constants, states.
// Depends on nothing.
`timescale 1ns / 1ps
package ciis_pkg;
    localparam int MAX_INTERVALS_DEF = 8;
    localparam int SLOTS_DEF         = 4;
    localparam int KEY_CHARS_DEF     = 15;
    localparam int KEY_W             = 120;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_SPLIT    = 2'd1,
        ST_BAD_AREA = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef struct packed {
        logic [7:0]  area_index;
        logic [63:0] key_high;
        logic [55:0] key_low;
    } in_item_t;

    typedef struct packed {
        logic [1:0] status;
        logic [2:0] interval_used;
        logic [2:0] interval_records;
        logic [3:0] interval_total;
    } out_item_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_SEL,
        S_LOAD_RD,
        S_LOAD_CAP,
        S_DECIDE,
        S_WRITE,
        S_OUT
    } state_t;

    // Mask for a key of the given number of characters (120-bit view)
    function automatic logic [KEY_W-1:0] key_mask(input int chars);
        logic [KEY_W-1:0] m;
        m = '0;
        for (int b = 0; b < 15; b++)
        begin
            if (b < chars)
                m[KEY_W-1-8*b -: 8] = 8'hFF;
        end
        return m;
    endfunction
endpackage

// ===== src/ciis_key_ram.sv =====
// Key slot memory: one write port, one registered read port.
// Depends on ciis_pkg.
`timescale 1ns / 1ps
module ciis_key_ram
    import ciis_pkg::*;
#(
    parameter int DEPTH = MAX_INTERVALS_DEF * SLOTS_DEF
)(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [KEY_W-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [KEY_W-1:0]         rdata
);
    logic [KEY_W-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

// ===== src/control_interval_insert_split_unit.sv =====
// Top level of the control interval insert/split unit.
// Depends on ciis_pkg, ciis_key_ram and the assertion macro header.
//
// Usage: one input channel (in_valid/in_ready, payload in_item) carries a
// key and an area index; one output channel (out_valid/out_ready, payload
// out_item) returns one status beat per input beat, in order.
// One item is processed at a time. Each scanned interval takes a memory read
// and then a compare (up to MAX_INTERVALS); each slot of the chosen interval
// (SLOTS_PER_INTERVAL) is loaded by a read and then a capture; then each slot
// is written back (up to SLOTS_PER_INTERVAL+1). A bad area index is answered
// at the accepting edge, so its result is offered the next cycle. The single
// key memory port sets this pace.
// The result sits in an output register; a new beat is not taken until it
// has been delivered, so a stalled receiver stops the input side.
// Reset clears the fill counts and sets one interval in use; the key memory
// is not cleared since only slots below a fill count are ever read.
`timescale 1ns / 1ps
`include "control_interval_insert_split_unit_defines.svh"
module control_interval_insert_split_unit
    import ciis_pkg::*;
#(
    parameter int MAX_INTERVALS      = MAX_INTERVALS_DEF,
    parameter int SLOTS_PER_INTERVAL = SLOTS_DEF,
    parameter int KEY_CHARS          = KEY_CHARS_DEF
)(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);
    localparam int IW    = $clog2(MAX_INTERVALS);
    localparam int SW    = $clog2(SLOTS_PER_INTERVAL);
    localparam int CW    = $clog2(SLOTS_PER_INTERVAL + 2);
    localparam int TW    = $clog2(MAX_INTERVALS + 1);
    localparam int DEPTH = MAX_INTERVALS * SLOTS_PER_INTERVAL;
    localparam int AW    = $clog2(DEPTH);
    localparam int KEEP  = (SLOTS_PER_INTERVAL + 1) / 2;
    localparam logic [KEY_W-1:0] KMASK = key_mask(KEY_CHARS);

    state_t state_reg, state_next;

    logic [CW-1:0]    fill_reg [MAX_INTERVALS];
    logic [TW-1:0]    total_reg, total_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [TW-1:0]    idx_reg, idx_next;      // scan index
    logic [IW-1:0]    ci_reg, ci_next;
    logic [CW-1:0]    cnt_reg, cnt_next;      // slot counter
    logic [KEY_W-1:0] buf_reg [SLOTS_PER_INTERVAL + 1];
    logic [CW-1:0]    pos_reg, pos_next;
    logic             split_reg, split_next;
    logic             out_valid_reg;
    out_item_t        out_reg, out_next;
    logic             out_load;

    logic             we;
    logic [AW-1:0]    waddr, raddr;
    logic [KEY_W-1:0] wdata, rdata;
    logic             cap_en, fill_we, fill2_we;
    logic [CW-1:0]    fill_wv;

    ciis_key_ram #(.DEPTH(DEPTH)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    assign in_ready  = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    function automatic logic [AW-1:0] slot_addr(input logic [IW-1:0] iv,
                                                 input logic [CW-1:0] sv);
        logic [AW+CW-1:0] a;
        a = (AW+CW)'(iv) * (AW+CW)'(SLOTS_PER_INTERVAL) + (AW+CW)'(sv);
        return a[AW-1:0];
    endfunction

    logic [IW-1:0] idx_i;
    logic [CW-1:0] fill_idx, fill_ci;
    logic [IW-1:0] new_iv;
    assign idx_i    = idx_reg[IW-1:0];
    assign fill_idx = fill_reg[idx_i];
    assign fill_ci  = fill_reg[ci_reg];
    assign new_iv   = total_reg[IW-1:0];

    // Next state, memory access and result
    always_comb
    begin
        state_next = state_reg;
        total_next = total_reg;
        key_next   = key_reg;
        idx_next   = idx_reg;
        ci_next    = ci_reg;
        cnt_next   = cnt_reg;
        pos_next   = pos_reg;
        split_next = split_reg;
        out_next   = out_reg;
        out_load   = 1'b0;
        we         = 1'b0;
        waddr      = '0;
        wdata      = '0;
        raddr      = '0;
        cap_en     = 1'b0;
        fill_we    = 1'b0;
        fill2_we   = 1'b0;
        fill_wv    = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    key_next = {in_item.key_high, in_item.key_low} & KMASK;
                    idx_next = '0;
                    if (in_item.area_index != 8'd0)
                    begin
                        out_next = '{status: ST_BAD_AREA, interval_used: 3'd0,
                                     interval_records: 3'd0,
                                     interval_total: 4'(total_reg)};
                        out_load = 1'b1;
                    end
                    else
                        state_next = S_SCAN_RD;
                end
            end
            S_SCAN_RD:
            begin
                if (idx_reg >= total_reg)
                begin
                    ci_next    = IW'(total_reg - TW'(1));
                    state_next = S_SEL;
                end
                else if (fill_idx == '0)
                    idx_next = idx_reg + TW'(1);
                else
                begin
                    raddr      = slot_addr(idx_i, fill_idx - CW'(1));
                    state_next = S_SCAN_CMP;
                end
            end
            S_SCAN_CMP:
            begin
                if (!(rdata < key_reg))
                begin
                    ci_next    = idx_i;
                    state_next = S_SEL;
                end
                else
                begin
                    idx_next   = idx_reg + TW'(1);
                    state_next = S_SCAN_RD;
                end
            end
            S_SEL:
            begin
                cnt_next = '0;
                pos_next = fill_ci;
                if (fill_ci == CW'(SLOTS_PER_INTERVAL) && total_reg >= TW'(MAX_INTERVALS))
                begin
                    out_next = '{status: ST_FULL, interval_used: 3'(ci_reg),
                                 interval_records: 3'(fill_ci),
                                 interval_total: 4'(total_reg)};
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
                else
                    state_next = S_LOAD_RD;
            end
            S_LOAD_RD:
            begin
                if (cnt_reg >= fill_ci)
                begin
                    cnt_next   = '0;
                    state_next = S_DECIDE;
                end
                else
                begin
                    raddr      = slot_addr(ci_reg, cnt_reg);
                    state_next = S_LOAD_CAP;
                end
            end
            S_LOAD_CAP:
            begin
                cap_en = 1'b1;
                if (key_reg < rdata && pos_reg == fill_ci)
                    pos_next = cnt_reg;
                cnt_next   = cnt_reg + CW'(1);
                state_next = S_LOAD_RD;
            end
            S_DECIDE:
            begin
                split_next = (fill_ci == CW'(SLOTS_PER_INTERVAL));
                cnt_next   = '0;
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                // merged slot cnt: below pos old, at pos key, above old[cnt-1]
                if (cnt_reg < pos_reg)
                    wdata = buf_reg[cnt_reg];
                else if (cnt_reg == pos_reg)
                    wdata = key_reg;
                else
                    wdata = buf_reg[cnt_reg - CW'(1)];
                we = 1'b1;
                if (split_reg && cnt_reg >= CW'(KEEP))
                    waddr = slot_addr(new_iv, cnt_reg - CW'(KEEP));
                else
                    waddr = slot_addr(ci_reg, cnt_reg);
                if (cnt_reg == fill_ci)
                begin
                    fill_we = 1'b1;
                    if (split_reg)
                    begin
                        fill_wv    = CW'(KEEP);
                        fill2_we   = 1'b1;
                        total_next = total_reg + TW'(1);
                        out_next = '{status: ST_SPLIT, interval_used: 3'(ci_reg),
                                     interval_records: 3'(KEEP),
                                     interval_total: 4'(total_reg + TW'(1))};
                    end
                    else
                    begin
                        fill_wv  = fill_ci + CW'(1);
                        out_next = '{status: ST_INSERTED, interval_used: 3'(ci_reg),
                                     interval_records: 3'(fill_ci + CW'(1)),
                                     interval_total: 4'(total_reg)};
                    end
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
                else
                    cnt_next = cnt_reg + CW'(1);
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            total_reg     <= TW'(1);
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_INTERVALS; i++)
                fill_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            total_reg <= total_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (fill_we)
                fill_reg[ci_reg] <= fill_wv;
            if (fill2_we)
                fill_reg[new_iv] <= CW'(SLOTS_PER_INTERVAL + 1 - KEEP);
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        idx_reg   <= idx_next;
        ci_reg    <= ci_next;
        cnt_reg   <= cnt_next;
        pos_reg   <= pos_next;
        split_reg <= split_next;
        out_reg   <= out_next;
        if (cap_en)
            buf_reg[cnt_reg[SW:0]] <= rdata;
    end

    `CIIS_ASSERT_IMP(a_no_accept_busy, in_valid && in_ready, state_reg == S_IDLE && !out_valid_reg, "beat taken while busy")
    `CIIS_ASSERT_IMP(a_total_range, 1'b1, total_reg >= TW'(1) && total_reg <= TW'(MAX_INTERVALS), "interval total out of range")
    `CIIS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_item), "result dropped under stall")
endmodule
